@@ design/srrw_pkg.sv @@
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants for the selective-repeat receive window.
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

  // Parameter defaults
  localparam int DEF_WINDOW_SIZE = 8;
  localparam int DEF_SEQ_SPACE   = 16;

  // Field widths
  localparam int SEQ_W     = 4;
  localparam int ACKF_W    = 5;
  localparam int CHK_W     = 16;
  localparam int PAY_W     = 160;   // 20 payload bytes
  localparam int ACKCHK_W  = 10;
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 176;

  // Checksum unit: 4 bytes per pass, 5 passes
  localparam int CHUNK_BYTES = 4;
  localparam int CHUNK_W     = CHUNK_BYTES * 8;
  localparam int NUM_CHUNKS  = PAY_W / CHUNK_W;
  localparam int CNT_W       = $clog2(NUM_CHUNKS);

  // ACK checksum offset: 20 fill bytes of 48
  localparam logic [ACKCHK_W-1:0] ACK_BASE = ACKCHK_W'(20 * 48);

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STORE,
    S_READ,
    S_SEND,
    S_ACK
  } state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } csum_stat_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } slot_ctl_t;

endpackage

`default_nettype wire

@@ design/srrw_csum.sv @@
// ----------------------------------------------------------------------------
// srrw_csum
// Iterative checksum unit: one adder folds four signed bytes per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_csum (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [srrw_pkg::SEQ_W-1:0]       seq,
  input  wire logic [srrw_pkg::ACKF_W-1:0]      ack,
  input  wire logic [srrw_pkg::PAY_W-1:0]       payload,
  input  wire logic [srrw_pkg::CHK_W-1:0]       chk,
  output srrw_pkg::csum_stat_t                  stat
);

  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [srrw_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [srrw_pkg::CHK_W-1:0]      acc_r, acc_nxt;
  logic [srrw_pkg::CHUNK_W-1:0]    chunk;
  logic [srrw_pkg::CHK_W-1:0]      chunk_sum;

  assign chunk = payload[cnt_r*srrw_pkg::CHUNK_W +: srrw_pkg::CHUNK_W];

  always_comb begin
    chunk_sum = '0;
    for (int b = 0; b < srrw_pkg::CHUNK_BYTES; b++) begin
      chunk_sum = chunk_sum + {{(srrw_pkg::CHK_W-8){chunk[8*b+7]}}, chunk[8*b +: 8]};
    end
  end

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = {{(srrw_pkg::CHK_W-srrw_pkg::SEQ_W){1'b0}}, seq}
              + {{(srrw_pkg::CHK_W-srrw_pkg::ACKF_W){ack[srrw_pkg::ACKF_W-1]}}, ack};
    end else if (run_r) begin
      acc_nxt = acc_r + chunk_sum;
      if (cnt_r == srrw_pkg::CNT_W'(srrw_pkg::NUM_CHUNKS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign stat.done = done_r;
  assign stat.ok   = (acc_r == chk);

endmodule

`default_nettype wire

@@ design/srrw_slots.sv @@
// ----------------------------------------------------------------------------
// srrw_slots
// Reorder slot store: payload memory with registered read, per-slot valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_slots #(
  parameter int WINDOW_SIZE = srrw_pkg::DEF_WINDOW_SIZE,
  parameter int IW          = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  srrw_pkg::slot_ctl_t               ctl,
  input  wire logic [IW-1:0]                wr_idx,
  input  wire logic [srrw_pkg::PAY_W-1:0]   wr_data,
  input  wire logic [IW-1:0]                rd_idx,
  output logic      [srrw_pkg::PAY_W-1:0]   rd_data,
  output logic      [WINDOW_SIZE-1:0]       valid
);

  logic [srrw_pkg::PAY_W-1:0] mem [WINDOW_SIZE];
  logic [srrw_pkg::PAY_W-1:0] rd_data_r;
  logic [WINDOW_SIZE-1:0]     valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.wr) begin
      valid_nxt[wr_idx] = 1'b1;
    end
    if (ctl.clr) begin
      valid_nxt[rd_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

`default_nettype wire

@@ design/selective_repeat_receive_window.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver half of selective-repeat ARQ: checksum, reorder window, ACK.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one data packet per beat (seq, ack field, checksum, 20 bytes).
//   out_* : results. tuser = kind (0 delivery, 1 ACK); tlast marks the ACK,
//           which is always the final beat caused by a good packet.
//   A packet with a bad checksum produces no beats and leaves state alone.
//   A good packet in the window is written to its reorder slot; then every
//   filled slot from the window head is delivered in order, then the ACK.
// Timing:
//   One packet at a time; in_tready is high only while the sequencer idles.
//   The checksum adder folds four bytes per cycle (5 passes). From accept
//   to the next accept a good packet that lands in the window passes the
//   check and store states, a slot read state plus a send state for each
//   of its D deliveries (0..WINDOW_SIZE), a final read state and the ACK
//   state. Outside the window store leads to ACK; a bad one goes idle.
// Reset: rst_n (sync, low) clears slot valid bits, window head and expected
//   sequence; no clearing pass.
// Stall: results sit in a single output register; the sequencer waits while
//   it is full and not taken, so nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receive_window #(
  parameter int WINDOW_SIZE = srrw_pkg::DEF_WINDOW_SIZE,
  parameter int SEQ_SPACE   = srrw_pkg::DEF_SEQ_SPACE
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: seq_num[3:0], ack_field[8:4], check_value[24:9],
  //           payload_low[88:25], payload_mid[152:89], payload_high[184:153]
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [srrw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: ack_seq[3:0], ack_check[13:4], out_low[77:14],
  //            out_mid[141:78], out_high[173:142]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [srrw_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tuser,   // kind
  output logic                                     out_tlast    // last
);

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;  // slot index
  localparam int AW = IW + 1;                                        // index sum
  localparam int EW = $clog2(SEQ_SPACE);                             // expected seq
  localparam int SW = ((EW > srrw_pkg::SEQ_W) ? EW : srrw_pkg::SEQ_W) + 1;
  localparam int CW = SW + 1;                                        // window compare

  // ---- input field split
  logic [srrw_pkg::SEQ_W-1:0]  in_seq;
  logic [srrw_pkg::ACKF_W-1:0] in_ack;
  logic                        in_fire;

  assign in_seq  = in_tdata[3:0];
  assign in_ack  = in_tdata[8:4];
  assign in_fire = in_tvalid && in_tready;

  // ---- packet latch
  logic [srrw_pkg::SEQ_W-1:0] seq_r;
  logic [srrw_pkg::CHK_W-1:0] chk_r;
  logic [srrw_pkg::PAY_W-1:0] pay_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      seq_r <= in_seq;
      chk_r <= in_tdata[24:9];
      pay_r <= in_tdata[184:25];
    end
  end

  // ---- window state
  srrw_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [EW-1:0] exp_r, exp_nxt;

  // ---- checksum unit
  srrw_pkg::csum_stat_t csum_stat;
  logic                 csum_start;

  srrw_csum u_csum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (csum_start),
    .seq     (in_seq),
    .ack     (in_ack),
    .payload (pay_r),
    .chk     (chk_r),
    .stat    (csum_stat)
  );

  // ---- window position of the packet
  logic          seq_ok;
  logic [SW-1:0] dist_raw, win_off;
  logic          in_win;
  logic [AW-1:0] idx_sum, idx_mod;
  logic [IW-1:0] wr_idx;

  always_comb begin
    seq_ok   = (9'(seq_r) < 9'(SEQ_SPACE));
    dist_raw = SW'(seq_r) + SW'(SEQ_SPACE) - SW'(exp_r);
    win_off  = (dist_raw >= SW'(SEQ_SPACE)) ? dist_raw - SW'(SEQ_SPACE) : dist_raw;
    in_win   = seq_ok && (CW'(win_off) < CW'(WINDOW_SIZE));
    idx_sum  = AW'(head_r) + AW'(win_off[IW-1:0]);
    idx_mod  = (idx_sum >= AW'(WINDOW_SIZE)) ? idx_sum - AW'(WINDOW_SIZE) : idx_sum;
    wr_idx   = idx_mod[IW-1:0];
  end

  // ---- slot store
  srrw_pkg::slot_ctl_t          slot_ctl;
  logic [srrw_pkg::PAY_W-1:0]   slot_rd;
  logic [WINDOW_SIZE-1:0]       slot_valid;

  srrw_slots #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .IW          (IW)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .wr_idx  (wr_idx),
    .wr_data (pay_r),
    .rd_idx  (head_r),
    .rd_data (slot_rd),
    .valid   (slot_valid)
  );

  // ---- output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r;
  logic                          out_last_r;
  logic [srrw_pkg::SEQ_W-1:0]    out_seq_r;
  logic [srrw_pkg::ACKCHK_W-1:0] out_chk_r;
  logic [srrw_pkg::PAY_W-1:0]    out_pay_r;
  logic                          out_free;
  logic                          load_data, load_ack;

  assign out_free = !out_valid_r || out_tready;

  // ---- sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srrw_pkg::S_IDLE:  if (in_fire) state_nxt = srrw_pkg::S_CHECK;
      srrw_pkg::S_CHECK: begin
        if (csum_stat.done) begin
          state_nxt = csum_stat.ok ? srrw_pkg::S_STORE : srrw_pkg::S_IDLE;
        end
      end
      srrw_pkg::S_STORE: state_nxt = in_win ? srrw_pkg::S_READ : srrw_pkg::S_ACK;
      srrw_pkg::S_READ:  state_nxt = slot_valid[head_r] ? srrw_pkg::S_SEND : srrw_pkg::S_ACK;
      srrw_pkg::S_SEND:  if (out_free) state_nxt = srrw_pkg::S_READ;
      srrw_pkg::S_ACK:   if (out_free) state_nxt = srrw_pkg::S_IDLE;
      default:           state_nxt = srrw_pkg::S_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    in_tready    = 1'b0;
    csum_start   = 1'b0;
    slot_ctl.wr  = 1'b0;
    slot_ctl.clr = 1'b0;
    load_data    = 1'b0;
    load_ack     = 1'b0;
    case (state_r)
      srrw_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        csum_start = in_tvalid;
      end
      srrw_pkg::S_STORE: slot_ctl.wr = in_win;
      srrw_pkg::S_SEND: begin
        load_data    = out_free;
        slot_ctl.clr = out_free;
      end
      srrw_pkg::S_ACK:  load_ack = out_free;
      default: begin
      end
    endcase
  end

  // head and expected sequence advance with each delivery
  always_comb begin
    head_nxt = head_r;
    exp_nxt  = exp_r;
    if (load_data) begin
      head_nxt = (AW'(head_r) + 1'b1 == AW'(WINDOW_SIZE)) ? '0 : head_r + 1'b1;
      exp_nxt  = (EW'(exp_r + 1'b1) == EW'(SEQ_SPACE) || (EW+1)'(exp_r) + 1'b1 == (EW+1)'(SEQ_SPACE))
               ? '0 : exp_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_data || load_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srrw_pkg::S_IDLE;
      head_r      <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_data) begin
      out_kind_r <= srrw_pkg::KIND_DATA;
      out_last_r <= 1'b0;
      out_seq_r  <= '0;
      out_chk_r  <= '0;
      out_pay_r  <= slot_rd;
    end else if (load_ack) begin
      out_kind_r <= srrw_pkg::KIND_ACK;
      out_last_r <= 1'b1;
      out_seq_r  <= seq_r;
      out_chk_r  <= {{(srrw_pkg::ACKCHK_W-srrw_pkg::SEQ_W-1){1'b0}}, seq_r, 1'b0}
                  + srrw_pkg::ACK_BASE;
      out_pay_r  <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_pay_r, out_chk_r, out_seq_r};

  // ---- checks
  // window head is never left filled once a packet is finished
  a_head_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srrw_pkg::S_IDLE) |-> !slot_valid[head_r])
    else $error("filled slot left at window head");

  // checksum result only arrives while the sequencer waits for it
  a_csum_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    csum_stat.done |-> (state_r == srrw_pkg::S_CHECK))
    else $error("checksum done outside check state");

  // tlast exactly on ACK beats
  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == srrw_pkg::KIND_ACK)))
    else $error("tlast does not match ACK kind");

  // a delivery clears the slot it was read from
  a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_data |=> !slot_valid[$past(head_r)])
    else $error("delivered slot still valid");

endmodule

`default_nettype wire
